// ===== rtl/pfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types, constants and arithmetic helpers of the procedural field
// source: register indexes, source kinds, hash constants, triangle fold.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int DIM_BITS       = 13;
  localparam int LEVEL_BITS     = 10;
  localparam int FUNC_BITS      = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WAVE_SCALE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WAVE_PHASE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RING_PHASE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_NOISE_SEED   = 3'd5;

  // source kinds
  localparam logic [FUNC_BITS-1:0] FUNC_WAVE   = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_RADIAL = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_NOISE  = 2'd2;

  // hash and mixer constants
  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [31:0] HASH_MUL_S = 32'd1274126177;
  localparam logic [31:0] MIX_MUL_A  = 32'd2246822519;
  localparam logic [31:0] MIX_MUL_B  = 32'd3266489917;

  localparam logic [17:0] PHASE_STEP  = 18'd173;
  localparam logic [10:0] SCALE_SKEW  = 11'd89;
  localparam logic [9:0]  LEVEL_MAX   = 10'd1000;
  localparam logic [10:0] NOISE_MOD   = 11'd1001;
  // 2^16 mod 1001 and 2^10 mod 1001
  localparam logic [8:0]  FOLD_16     = 9'd471;
  localparam logic [4:0]  FOLD_10     = 5'd23;
  localparam int          RING_CENTER = 256;
  // ceil(2^28 / 511), exact for products up to 511000
  localparam logic [19:0] TRI_RECIP   = 20'd525315;

  typedef struct packed {
    logic                  valid;
    logic [FUNC_BITS-1:0]  func;
    logic [LEVEL_BITS-1:0] wave_lvl;
    logic [LEVEL_BITS-1:0] noise_lvl;
  } pfs_ctl_t;

  typedef struct packed {
    logic                qbit;
    logic [DIM_BITS-1:0] rem;
  } pfs_step_t;

  // triangle fold of the low ten bits, scaled by 1000
  function automatic logic [18:0] tri_scaled(input logic [9:0] v);
    logic [8:0] f;
    f = v[9] ? ~v[8:0] : v[8:0];
    return 19'(f) * 19'd1000;
  endfunction

  // divide a scaled fold value by 511
  function automatic logic [LEVEL_BITS-1:0] tri_level(input logic [18:0] t);
    logic [38:0] p;
    p = 39'(t) * 39'(TRI_RECIP);
    return p[37:28];
  endfunction

  // one restoring division step
  function automatic pfs_step_t div_step(input logic [DIM_BITS-1:0] rem,
                                         input logic din,
                                         input logic [DIM_BITS-1:0] dvs);
    logic [DIM_BITS:0] part;
    pfs_step_t         res;
    part = {rem, din};
    if (part >= {1'b0, dvs}) begin
      res.qbit = 1'b1;
      res.rem  = DIM_BITS'(part - {1'b0, dvs});
    end else begin
      res.qbit = 1'b0;
      res.rem  = part[DIM_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/pfs_front.sv =====
// ----------------------------------------------------------------------------
// pfs_front
// Entry pipeline: wave phase and triangle level, noise hash, mixer and
// reduction modulo 1001. Eleven register stages.
// ----------------------------------------------------------------------------
module pfs_front #(
  parameter int COORD_BITS = pfs_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic [9:0]                     wave_scale,
  input  logic [31:0]                    wave_phase,
  input  logic [31:0]                    noise_seed,
  input  logic                           in_valid,
  input  logic [pfs_pkg::FUNC_BITS-1:0]  func,
  input  logic [COORD_BITS-1:0]          px,
  input  logic [COORD_BITS-1:0]          py,
  input  logic [7:0]                     layer,
  output pfs_pkg::pfs_ctl_t              ctl,
  output logic [COORD_BITS-1:0]          x_out,
  output logic [COORD_BITS-1:0]          y_out
);
  import pfs_pkg::*;

  localparam int NS  = 11;
  localparam int PW  = COORD_BITS + 11;
  localparam int TW  = COORD_BITS + 7;
  localparam int QW3 = 2 * TW;
  // ceil(2^(TW+1) / 3), exact divide by three for TW-bit values
  localparam int M3  = (2 ** (TW + 1) + 2) / 3;

  logic [NS-1:0]          vld;
  logic [FUNC_BITS-1:0]   fn [NS];
  logic [COORD_BITS-1:0]  xs [NS];
  logic [COORD_BITS-1:0]  ys [NS];

  logic [10:0] sc;
  logic [10:0] sc2;
  logic [31:0] hash_k;

  logic [PW-1:0]  a_wa, a_wb;
  logic [9:0]     a_ph;
  logic [31:0]    a_kx, a_ky, a_ks;
  logic [9:0]     b_v0;
  logic [TW-1:0]  b_t;
  logic [31:0]    b_k1;
  logic [9:0]     c_v0;
  logic [QW3-1:0] c_q3;
  logic [31:0]    c_k2;
  logic [9:0]     d_v;
  logic [31:0]    d_k3;
  logic [18:0]    e_t;
  logic [31:0]    e_k4;
  logic [9:0]     f_wl;
  logic [31:0]    f_k5;
  logic [9:0]     g_wl, h_wl, i_wl, j_wl, k_wl;
  logic [24:0]    g_n1;
  logic [19:0]    h_n2;
  logic [14:0]    i_n3;
  logic [10:0]    j_n4;
  logic [9:0]     k_nl;

  assign sc     = {1'b0, wave_scale} + 11'd1;
  assign sc2    = sc + SCALE_SKEW;
  assign hash_k = noise_seed ^ a_kx ^ a_ky ^ a_ks;

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // kind and coordinates ride along
  always_ff @(posedge clk) begin
    if (adv) begin
      fn[0] <= func;
      xs[0] <= px;
      ys[0] <= py;
      for (int i = 1; i < NS; i++) begin
        fn[i] <= fn[i-1];
        xs[i] <= xs[i-1];
        ys[i] <= ys[i-1];
      end
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // products of coordinates
      a_wa <= PW'(px) * PW'(sc);
      a_wb <= PW'(py) * PW'(sc2);
      a_ph <= wave_phase[9:0] + 10'(18'(layer) * PHASE_STEP);
      a_kx <= 32'(px) * HASH_MUL_X;
      a_ky <= 32'(py) * HASH_MUL_Y;
      a_ks <= 32'(layer) * HASH_MUL_S;
      // only the low ten bits of the wave phase reach the fold
      b_v0 <= 10'(a_wa >> 5) + a_ph;
      b_t  <= TW'(a_wb >> 4);
      b_k1 <= hash_k ^ (hash_k >> 16);
      // divide by three through the reciprocal
      c_v0 <= b_v0;
      c_q3 <= QW3'(b_t) * QW3'(M3);
      c_k2 <= b_k1 * MIX_MUL_A;
      d_v  <= c_v0 + c_q3[TW+10:TW+1];
      d_k3 <= c_k2 ^ (c_k2 >> 13);
      // triangle fold and second mixer product
      e_t  <= tri_scaled(d_v);
      e_k4 <= d_k3 * MIX_MUL_B;
      f_wl <= tri_level(e_t);
      f_k5 <= e_k4 ^ (e_k4 >> 16);
      // modulo 1001 by folding high digits down
      g_wl <= f_wl;
      g_n1 <= 25'(f_k5[31:16]) * 25'(FOLD_16) + 25'(f_k5[15:0]);
      h_wl <= g_wl;
      h_n2 <= 20'(g_n1[24:10]) * 20'(FOLD_10) + 20'(g_n1[9:0]);
      i_wl <= h_wl;
      i_n3 <= 15'(h_n2[19:10]) * 15'(FOLD_10) + 15'(h_n2[9:0]);
      j_wl <= i_wl;
      j_n4 <= 11'(i_n3[14:10]) * 11'(FOLD_10) + 11'(i_n3[9:0]);
      k_wl <= j_wl;
      k_nl <= (j_n4 >= NOISE_MOD) ? 10'(j_n4 - NOISE_MOD) : 10'(j_n4);
    end
  end

  assign ctl.valid     = vld[NS-1];
  assign ctl.func      = fn[NS-1];
  assign ctl.wave_lvl  = k_wl;
  assign ctl.noise_lvl = k_nl;
  assign x_out         = xs[NS-1];
  assign y_out         = ys[NS-1];

endmodule

// ===== rtl/pfs_div_cell.sv =====
// ----------------------------------------------------------------------------
// pfs_div_cell
// One cell of the division chain: a restoring step for both coordinates,
// producing one quotient bit of x*512/width and y*512/height.
// ----------------------------------------------------------------------------
module pfs_div_cell #(
  parameter int COORD_BITS = pfs_pkg::COORD_BITS_DEF,
  parameter int BIT        = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic [pfs_pkg::DIM_BITS-1:0]      w,
  input  logic [pfs_pkg::DIM_BITS-1:0]      h,
  input  pfs_pkg::pfs_ctl_t                 ctl_in,
  input  logic [COORD_BITS-1:0]             x_in,
  input  logic [COORD_BITS-1:0]             y_in,
  input  logic [COORD_BITS+8:0]             qx_in,
  input  logic [COORD_BITS+8:0]             qy_in,
  input  logic [pfs_pkg::DIM_BITS-1:0]      rx_in,
  input  logic [pfs_pkg::DIM_BITS-1:0]      ry_in,
  output pfs_pkg::pfs_ctl_t                 ctl_out,
  output logic [COORD_BITS-1:0]             x_out,
  output logic [COORD_BITS-1:0]             y_out,
  output logic [COORD_BITS+8:0]             qx_out,
  output logic [COORD_BITS+8:0]             qy_out,
  output logic [pfs_pkg::DIM_BITS-1:0]      rx_out,
  output logic [pfs_pkg::DIM_BITS-1:0]      ry_out
);
  import pfs_pkg::*;

  localparam int QW = COORD_BITS + 9;

  logic      xb, yb;
  pfs_step_t stx, sty;

  // dividend bit: the coordinate shifted up by nine
  if (BIT >= 9) begin : g_coord_bit
    assign xb = x_in[BIT-9];
    assign yb = y_in[BIT-9];
  end else begin : g_zero_bit
    assign xb = 1'b0;
    assign yb = 1'b0;
  end

  assign stx = div_step(rx_in, xb, w);
  assign sty = div_step(ry_in, yb, h);

  // control to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  // data to the neighbor
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_out.func      <= ctl_in.func;
      ctl_out.wave_lvl  <= ctl_in.wave_lvl;
      ctl_out.noise_lvl <= ctl_in.noise_lvl;
      x_out  <= x_in;
      y_out  <= y_in;
      qx_out <= {qx_in[QW-2:0], stx.qbit};
      qy_out <= {qy_in[QW-2:0], sty.qbit};
      rx_out <= stx.rem;
      ry_out <= sty.rem;
    end
  end

endmodule

// ===== rtl/pfs_tail.sv =====
// ----------------------------------------------------------------------------
// pfs_tail
// Radial distance from the normalized coordinates, its triangle level,
// and the output register that picks the level of the source kind.
// ----------------------------------------------------------------------------
module pfs_tail #(
  parameter int COORD_BITS = pfs_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic [31:0]                     ring_phase,
  input  pfs_pkg::pfs_ctl_t               ctl_in,
  input  logic [COORD_BITS+8:0]           qx,
  input  logic [COORD_BITS+8:0]           qy,
  output logic                            out_valid,
  output logic [pfs_pkg::LEVEL_BITS-1:0]  level
);
  import pfs_pkg::*;

  localparam int QW  = COORD_BITS + 9;
  localparam int SQW = 2 * QW + 2;

  logic signed [QW:0] dx, dy;
  logic [SQW-1:0]     sqx_full, sqy_full;
  logic [15:0]        sum;

  pfs_ctl_t    c1, c2, c3;
  logic [15:0] sqx, sqy;
  logic [18:0] r_t;
  logic [9:0]  r_lvl;

  // offsets from the field center
  assign dx       = $signed({1'b0, qx}) - $signed((QW+1)'(RING_CENTER));
  assign dy       = $signed({1'b0, qy}) - $signed((QW+1)'(RING_CENTER));
  assign sqx_full = SQW'(dx * dx);
  assign sqy_full = SQW'(dy * dy);
  // distance >>> 6 keeps bits 15:6 of the sum in its low ten bits
  assign sum      = sqx + sqy;

  // control line
  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid  <= 1'b0;
      c2.valid  <= 1'b0;
      c3.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      c1.valid  <= ctl_in.valid;
      c2.valid  <= c1.valid;
      c3.valid  <= c2.valid;
      out_valid <= c3.valid;
    end
  end

  // radial stages and level select
  always_ff @(posedge clk) begin
    if (adv) begin
      c1.func      <= ctl_in.func;
      c1.wave_lvl  <= ctl_in.wave_lvl;
      c1.noise_lvl <= ctl_in.noise_lvl;
      c2.func      <= c1.func;
      c2.wave_lvl  <= c1.wave_lvl;
      c2.noise_lvl <= c1.noise_lvl;
      c3.func      <= c2.func;
      c3.wave_lvl  <= c2.wave_lvl;
      c3.noise_lvl <= c2.noise_lvl;
      sqx   <= sqx_full[15:0];
      sqy   <= sqy_full[15:0];
      r_t   <= tri_scaled(sum[15:6] + ring_phase[9:0]);
      r_lvl <= tri_level(r_t);
      case (c3.func)
        FUNC_WAVE:   level <= c3.wave_lvl;
        FUNC_RADIAL: level <= r_lvl;
        FUNC_NOISE:  level <= c3.noise_lvl;
        default:     level <= '0;
      endcase
    end
  end

endmodule

// ===== rtl/procedural_field_source.sv =====
// ----------------------------------------------------------------------------
// procedural_field_source
// Per-pixel procedural texture source: wave, radial and noise kinds, each
// giving one level from 0 to 1000 per transfer.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_ready is high and returns one level per
// item, in order. The pipeline has eleven entry stages for the wave and noise
// arithmetic, then a chain of COORD_BITS + 9 division cells that each settle
// one quotient bit of the radial normalization, then four radial and output
// stages. The whole pipeline moves together; in_ready is low only while a
// finished level waits in the output register and out_ready is low. The user
// must write configuration through the plain write port only while no item
// is in flight; the block itself does not enforce this.
module procedural_field_source #(
  parameter int COORD_BITS = pfs_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pfs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pfs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pfs_pkg::FUNC_BITS-1:0]      func,
  input  logic [COORD_BITS-1:0]              px,
  input  logic [COORD_BITS-1:0]              py,
  input  logic [7:0]                         layer,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pfs_pkg::LEVEL_BITS-1:0]     level
);
  import pfs_pkg::*;

  localparam int QW = COORD_BITS + 9;

  logic [9:0]          wave_scale;
  logic [31:0]         wave_phase;
  logic [31:0]         ring_phase;
  logic [DIM_BITS-1:0] field_width;
  logic [DIM_BITS-1:0] field_height;
  logic [31:0]         noise_seed;

  logic                adv;
  logic [DIM_BITS-1:0] w_eff, h_eff;

  pfs_ctl_t              ctl_c [QW+1];
  logic [COORD_BITS-1:0] x_c   [QW+1];
  logic [COORD_BITS-1:0] y_c   [QW+1];
  logic [QW-1:0]         qx_c  [QW+1];
  logic [QW-1:0]         qy_c  [QW+1];
  logic [DIM_BITS-1:0]   rx_c  [QW+1];
  logic [DIM_BITS-1:0]   ry_c  [QW+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_scale   <= '0;
      wave_phase   <= '0;
      ring_phase   <= '0;
      field_width  <= DIM_BITS'(1);
      field_height <= DIM_BITS'(1);
      noise_seed   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WAVE_SCALE:   wave_scale   <= cfg_data[9:0];
        REG_WAVE_PHASE:   wave_phase   <= cfg_data;
        REG_RING_PHASE:   ring_phase   <= cfg_data;
        REG_FIELD_WIDTH:  field_width  <= cfg_data[DIM_BITS-1:0];
        REG_FIELD_HEIGHT: field_height <= cfg_data[DIM_BITS-1:0];
        REG_NOISE_SEED:   noise_seed   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // zero size counts as one
  assign w_eff = (field_width == '0) ? DIM_BITS'(1) : field_width;
  assign h_eff = (field_height == '0) ? DIM_BITS'(1) : field_height;

  // the pipeline moves unless the output holds an untaken level
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // wave and noise stages
  pfs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .wave_scale (wave_scale),
    .wave_phase (wave_phase),
    .noise_seed (noise_seed),
    .in_valid   (in_valid),
    .func       (func),
    .px         (px),
    .py         (py),
    .layer      (layer),
    .ctl        (ctl_c[0]),
    .x_out      (x_c[0]),
    .y_out      (y_c[0])
  );

  assign qx_c[0] = '0;
  assign qy_c[0] = '0;
  assign rx_c[0] = '0;
  assign ry_c[0] = '0;

  // division chain, most significant quotient bit first
  for (genvar i = 0; i < QW; i++) begin : g_cell
    pfs_div_cell #(.COORD_BITS(COORD_BITS), .BIT(QW - 1 - i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .w       (w_eff),
      .h       (h_eff),
      .ctl_in  (ctl_c[i]),
      .x_in    (x_c[i]),
      .y_in    (y_c[i]),
      .qx_in   (qx_c[i]),
      .qy_in   (qy_c[i]),
      .rx_in   (rx_c[i]),
      .ry_in   (ry_c[i]),
      .ctl_out (ctl_c[i+1]),
      .x_out   (x_c[i+1]),
      .y_out   (y_c[i+1]),
      .qx_out  (qx_c[i+1]),
      .qy_out  (qy_c[i+1]),
      .rx_out  (rx_c[i+1]),
      .ry_out  (ry_c[i+1])
    );
  end

  // radial level and output register
  pfs_tail #(.COORD_BITS(COORD_BITS)) u_tail (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ring_phase (ring_phase),
    .ctl_in     (ctl_c[QW]),
    .qx         (qx_c[QW]),
    .qy         (qy_c[QW]),
    .out_valid  (out_valid),
    .level      (level)
  );

`ifndef SYNTHESIS
  // a delivered level is always in range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= LEVEL_MAX)
    else $error("level above maximum");

  // a held output blocks new transfers
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output held");

  // division leaves remainders below the divisors
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    ctl_c[QW].valid |-> (rx_c[QW] < w_eff) && (ry_c[QW] < h_eff))
    else $error("division remainder out of range");

  // entry stages give levels in range
  a_front_range: assert property (@(posedge clk) disable iff (rst)
    ctl_c[0].valid |-> (ctl_c[0].noise_lvl <= LEVEL_MAX)
                       && (ctl_c[0].wave_lvl <= LEVEL_MAX))
    else $error("entry level above maximum");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the procedural field source: a directed table of
// pixel items followed by random traffic under several register settings,
// each level compared against an in-bench model of the source kinds or a table level.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pfs_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int LATENCY   = 36;
  localparam int MAX_CYCLE = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [FUNC_BITS-1:0] func = '0;
  logic [CB-1:0] px = '0;
  logic [CB-1:0] py = '0;
  logic [7:0]  layer = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [LEVEL_BITS-1:0] level;

  procedural_field_source DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the registers
  logic [9:0]  sh_scale;
  logic [31:0] sh_wphase, sh_rphase, sh_seed;
  logic [12:0] sh_width, sh_height;

  logic [9:0] level_q[$];
  int mismatches = 0;
  int checked = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [9:0] fold_level(logic [31:0] v);
    logic [31:0] t;
    t = v & 32'd1023;
    if (t >= 32'd512) t = 32'd1023 - t;
    return 10'((t * 32'd1000) / 32'd511);
  endfunction

  function automatic logic [9:0] field_level(logic [1:0] f, logic [CB-1:0] xi,
                                             logic [CB-1:0] yi, logic [7:0] s);
    logic [31:0] x, y, sc, v, w, h, dx, dy, sum, ring_dist, k;
    x = 32'(xi);
    y = 32'(yi);
    case (f)
      FUNC_WAVE: begin
        sc = 32'(sh_scale) + 32'd1;
        v = (x * sc) / 32'd32 + (y * (sc + 32'd89)) / 32'd48
            + sh_wphase + 32'(s) * 32'd173;
        return fold_level(v);
      end
      FUNC_RADIAL: begin
        w = (sh_width == 0) ? 32'd1 : 32'(sh_width);
        h = (sh_height == 0) ? 32'd1 : 32'(sh_height);
        dx = (x * 32'd512) / w - 32'd256;
        dy = (y * 32'd512) / h - 32'd256;
        sum = dx * dx + dy * dy;
        ring_dist = 32'($signed(sum) >>> 6);
        return fold_level(ring_dist + sh_rphase);
      end
      FUNC_NOISE: begin
        k = sh_seed ^ (x * 32'd374761393) ^ (y * 32'd668265263)
            ^ (32'(s) * 32'd1274126177);
        k ^= k >> 16;
        k *= 32'd2246822519;
        k ^= k >> 13;
        k *= 32'd3266489917;
        k ^= k >> 16;
        return 10'(k % 32'd1001);
      end
      default: return 10'd0;
    endcase
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected level %0d", level);
        end else begin
          logic [9:0] want;
          want = level_q.pop_front();
          checked++;
          if (want !== level) begin
            mismatches++;
            if (mismatches <= 10)
              $display("level mismatch: expected %0d got %0d", want, level);
          end
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 3) out_ready <= 1'b0;
      else if (!out_ready) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 9) != 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WAVE_SCALE:   sh_scale  = val[9:0];
      REG_WAVE_PHASE:   sh_wphase = val;
      REG_RING_PHASE:   sh_rphase = val;
      REG_FIELD_WIDTH:  sh_width  = val[12:0];
      REG_FIELD_HEIGHT: sh_height = val[12:0];
      REG_NOISE_SEED:   sh_seed   = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one transfer with an optional gap before it; queues its expected level
  task automatic send_pixel(logic [1:0] f, logic [CB-1:0] x, logic [CB-1:0] y,
                            logic [7:0] s, bit gaps);
    int g;
    if (gaps) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    func <= f; px <= x; py <= y; layer <= s;
    level_q.push_back(field_level(f, x, y, s));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  typedef struct {
    logic [1:0] f;
    logic [CB-1:0] x, y;
    logic [7:0] s;
    bit has_lvl;
    logic [9:0] lvl;
  } pixel_row_t;

  pixel_row_t rows[] = '{
    '{FUNC_WAVE,   0,     0,     0,   1'b1, 10'd0},
    '{FUNC_RADIAL, 0,     0,     0,   1'b0, 10'd0},
    '{FUNC_NOISE,  0,     0,     0,   1'b0, 10'd0},
    '{2'd3,        0,     0,     0,   1'b1, 10'd0},
    '{2'd3,        12'hfff, 12'hfff, 8'hff, 1'b1, 10'd0},
    '{FUNC_WAVE,   12'hfff, 12'hfff, 8'hff, 1'b0, 10'd0},
    '{FUNC_RADIAL, 12'hfff, 12'hfff, 8'hff, 1'b0, 10'd0},
    '{FUNC_NOISE,  12'hfff, 12'hfff, 8'hff, 1'b0, 10'd0},
    '{FUNC_WAVE,   12'h800, 0,     0,   1'b0, 10'd0},
    '{FUNC_WAVE,   0,     12'h800, 8'h80, 1'b0, 10'd0},
    '{FUNC_NOISE,  1,     0,     0,   1'b0, 10'd0},
    '{FUNC_NOISE,  0,     1,     1,   1'b0, 10'd0},
    '{FUNC_RADIAL, 12'h555, 12'haaa, 0, 1'b0, 10'd0},
    '{FUNC_WAVE,   12'haaa, 12'h555, 8'h55, 1'b0, 10'd0}
  };

  task automatic random_phase(int n, int max_coord);
    logic [1:0] f;
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      send_pixel(f, CB'($urandom_range(0, max_coord)), CB'($urandom_range(0, max_coord)),
                 8'($urandom), ($urandom_range(0, 4) != 0) && (i % 200 > 40));
    end
    drain();
  endtask

  task automatic random_regs();
    write_reg(REG_WAVE_SCALE, $urandom_range(0, 1023));
    write_reg(REG_WAVE_PHASE, $urandom);
    write_reg(REG_RING_PHASE, $urandom);
    write_reg(REG_FIELD_WIDTH, $urandom_range(0, 4096));
    write_reg(REG_FIELD_HEIGHT, $urandom_range(0, 4096));
    write_reg(REG_NOISE_SEED, $urandom);
  endtask

  initial begin
    sh_scale = '0; sh_wphase = '0; sh_rphase = '0; sh_seed = '0;
    sh_width = 13'd1; sh_height = 13'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset values
    foreach (rows[i]) begin
      send_pixel(rows[i].f, rows[i].x, rows[i].y, rows[i].s, 1'b0);
      if (rows[i].has_lvl) level_q[$] = rows[i].lvl;
    end
    drain();

    // extremes of every register
    write_reg(REG_WAVE_SCALE, 32'd1023);
    write_reg(REG_WAVE_PHASE, 32'hffff_ffff);
    write_reg(REG_RING_PHASE, 32'hffff_ffff);
    write_reg(REG_FIELD_WIDTH, 32'd4096);
    write_reg(REG_FIELD_HEIGHT, 32'd0);
    write_reg(REG_NOISE_SEED, 32'hffff_ffff);
    write_reg(3'd7, 32'h1234_5678);
    foreach (rows[i]) send_pixel(rows[i].f, rows[i].x, rows[i].y, rows[i].s, 1'b0);
    drain();

    // receiver holds off while the sender keeps offering items
    hold_off = 1'b1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(100, 4095);
    join

    // several random settings, small coordinates in one of them
    write_reg(REG_FIELD_WIDTH, 32'd0);
    write_reg(REG_FIELD_HEIGHT, 32'd4096);
    random_phase(300, 4095);
    for (int p = 0; p < 4; p++) begin
      random_regs();
      random_phase(350, (p == 1) ? 63 : 4095);
    end

    $display("covered %0d levels over wave, radial, noise and the unused kind,",
             checked);
    $display("across reset, extreme and random register settings with stalls");
    if (mismatches == 0 && level_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches, %0d levels outstanding", mismatches, level_q.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
